### rtl/lvl_pkg.sv
package lvl_pkg;

  localparam int MAX_LIGHTS_DEF = 4;

  // input beat: slot, pos xyz, normal xyz, color rgb, intensity, zero pad
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 96;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHADE = 1'b1;

  typedef struct packed {
    logic               is_shade;
    logic [1:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        color_r;
    logic [15:0]        color_g;
    logic [15:0]        color_b;
    logic [31:0]        intensity;
  } job_t;

endpackage

### rtl/lvl_front.sv
module lvl_front #(
  parameter int MAX_LIGHTS = lvl_pkg::MAX_LIGHTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lvl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  output logic                           job_valid,
  output lvl_pkg::job_t                  job,
  input  logic                           job_pop
);

  lvl_pkg::job_t in_job;
  lvl_pkg::job_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          drop;
  logic          push;
  logic          pop;

  always_comb begin
    in_job.is_shade  = (in_tuser == lvl_pkg::OP_SHADE);
    in_job.slot      = in_tdata[1:0];
    in_job.pos_x     = in_tdata[33:2];
    in_job.pos_y     = in_tdata[65:34];
    in_job.pos_z     = in_tdata[97:66];
    in_job.normal_x  = in_tdata[113:98];
    in_job.normal_y  = in_tdata[129:114];
    in_job.normal_z  = in_tdata[145:130];
    in_job.color_r   = in_tdata[161:146];
    in_job.color_g   = in_tdata[177:162];
    in_job.color_b   = in_tdata[193:178];
    in_job.intensity = in_tdata[225:194];
  end

  // writes to a slot past the table never reach the back end
  assign drop = !in_job.is_shade && ({3'b000, in_job.slot} >= 5'(MAX_LIGHTS));

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && !drop;
  assign pop       = job_pop && (cnt_r != 2'd0);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= in_job;
        wr_ptr_r      <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/lvl_back.sv
module lvl_back #(
  parameter int MAX_LIGHTS = lvl_pkg::MAX_LIGHTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [2:0]                      light_count,
  input  logic                            job_valid,
  input  lvl_pkg::job_t                   job,
  output logic                            job_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lvl_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  localparam int LIDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ROOT0 = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_CDIV  = 4'd5;
  localparam logic [3:0] S_WCOL  = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_PMUL  = 4'd8;
  localparam logic [3:0] S_PDIV0 = 4'd9;
  localparam logic [3:0] S_PDIV  = 4'd10;
  localparam logic [3:0] S_ACC   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  // light table
  logic [31:0] tab_pos_r [MAX_LIGHTS][3];
  logic [15:0] tab_col_r [MAX_LIGHTS][3];
  logic [31:0] tab_pow_r [MAX_LIGHTS];

  logic [3:0]         st_r, st_nxt;
  logic [4:0]         li_r, n_r, n_calc, li_inc;
  logic [5:0]         cnt_r;
  logic [LIDX_W-1:0]  lidx, widx;
  logic [4:0]         slot_ext;
  logic               last_light;

  logic signed [31:0] vtx_r [3];
  logic signed [15:0] nrm_r [3];
  logic [15:0]        kd_r  [3];
  logic signed [32:0] d_r   [3];
  logic [63:0]        s_r;
  logic signed [50:0] dot_r;

  logic [63:0]        res_r, sbit_r, srem_r, strial;
  logic [31:0]        crem_r;
  logic [49:0]        cq_r;
  logic [32:0]        cr2;
  logic               cge;

  logic [17:0]        wcol_r [3];
  logic [49:0]        w_r    [3];
  logic [63:0]        c2sh_r;
  logic [100:0]       p_r    [3];
  logic [63:0]        prem_r [3];
  logic [31:0]        pq_r   [3];
  logic               psat_r [3];
  logic [31:0]        acc_r  [3];
  logic               clip_r;

  logic [31:0]        col_prod [3];
  logic [49:0]        w_prod   [3];
  logic [65:0]        pp       [3];
  logic [64:0]        pr2      [3];
  logic               pge      [3];
  logic [64:0]        pdiff    [3];
  logic [32:0]        part     [3];
  logic [33:0]        accsum   [3];

  logic signed [32:0] d_sel;
  logic signed [15:0] nrm_sel;
  logic [32:0]        ux;
  logic [63:0]        sq_lo, sq_q;
  logic signed [48:0] dprod;

  logic                            out_valid_r;
  logic [lvl_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_user_r;
  logic                            out_load;

  assign lidx       = li_r[LIDX_W-1:0];
  assign slot_ext   = {3'b000, job.slot};
  assign widx       = slot_ext[LIDX_W-1:0];
  assign n_calc     = ({2'b00, light_count} > 5'(MAX_LIGHTS)) ? 5'(MAX_LIGHTS)
                                                              : {2'b00, light_count};
  assign li_inc     = li_r + 5'd1;
  assign last_light = (li_inc == n_r);
  assign job_pop    = (st_r == S_IDLE) && job_valid;
  assign out_load   = (st_r == S_DONE) && (!out_valid_r || out_tready);

  // squares and dot product terms, one axis a cycle
  assign d_sel   = d_r[cnt_r[1:0]];
  assign nrm_sel = nrm_r[cnt_r[1:0]];
  assign ux      = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
  assign sq_lo   = ux[31:0] * ux[31:0];
  // a magnitude of 2^32 has zero low bits, its square is 2^64
  assign sq_q    = ux[32] ? 64'h4000_0000_0000_0000 : {2'b00, sq_lo[63:2]};
  assign dprod   = d_sel * nrm_sel;

  assign strial = res_r + sbit_r;
  assign cr2    = {crem_r, cq_r[49]};
  assign cge    = (cr2 >= {1'b0, res_r[31:0]});

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_prod[ch] = tab_col_r[lidx][ch] * kd_r[ch];
      w_prod[ch]   = wcol_r[ch] * tab_pow_r[lidx];
      pp[ch]       = w_r[ch] * c2sh_r[63:48];
      pr2[ch]      = {prem_r[ch], pq_r[ch][31]};
      pge[ch]      = (pr2[ch] >= {1'b0, s_r});
      pdiff[ch]    = pr2[ch] - {1'b0, s_r};
      part[ch]     = psat_r[ch] ? {1'b1, 32'h0} : {1'b0, pq_r[ch]};
      accsum[ch]   = {2'b00, acc_r[ch]} + {1'b0, part[ch]};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (job_valid && job.is_shade) begin
          st_nxt = (n_calc == 5'd0) ? S_DONE : S_DIFF;
        end
      end
      S_DIFF:  st_nxt = S_SQ;
      S_SQ:    st_nxt = (cnt_r == 6'd2) ? S_ROOT0 : S_SQ;
      S_ROOT0: begin
        if (s_r == 64'd0 || dot_r <= 51'sd0) begin
          st_nxt = last_light ? S_DONE : S_DIFF;
        end else begin
          st_nxt = S_SQRT;
        end
      end
      S_SQRT:  st_nxt = sbit_r[0] ? S_CDIV : S_SQRT;
      S_CDIV:  st_nxt = (cnt_r == 6'd49) ? S_WCOL : S_CDIV;
      S_WCOL:  st_nxt = S_WMUL;
      S_WMUL:  st_nxt = S_PMUL;
      S_PMUL:  st_nxt = (cnt_r == 6'd3) ? S_PDIV0 : S_PMUL;
      S_PDIV0: st_nxt = S_PDIV;
      S_PDIV:  st_nxt = (cnt_r == 6'd31) ? S_ACC : S_PDIV;
      S_ACC:   st_nxt = last_light ? S_DONE : S_DIFF;
      S_DONE:  st_nxt = out_load ? S_IDLE : S_DONE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {acc_r[2], acc_r[1], acc_r[0]};
        out_user_r  <= clip_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_IDLE: begin
          if (job_valid && !job.is_shade) begin
            tab_pos_r[widx][0] <= job.pos_x;
            tab_pos_r[widx][1] <= job.pos_y;
            tab_pos_r[widx][2] <= job.pos_z;
            tab_col_r[widx][0] <= job.color_r;
            tab_col_r[widx][1] <= job.color_g;
            tab_col_r[widx][2] <= job.color_b;
            tab_pow_r[widx]    <= job.intensity;
          end
          vtx_r[0] <= job.pos_x;
          vtx_r[1] <= job.pos_y;
          vtx_r[2] <= job.pos_z;
          nrm_r[0] <= job.normal_x;
          nrm_r[1] <= job.normal_y;
          nrm_r[2] <= job.normal_z;
          kd_r[0]  <= job.color_r;
          kd_r[1]  <= job.color_g;
          kd_r[2]  <= job.color_b;
          li_r     <= 5'd0;
          n_r      <= n_calc;
          clip_r   <= 1'b0;
          for (int ch = 0; ch < 3; ch++) begin
            acc_r[ch] <= 32'd0;
          end
        end
        S_DIFF: begin
          for (int ch = 0; ch < 3; ch++) begin
            d_r[ch] <= $signed({tab_pos_r[lidx][ch][31], tab_pos_r[lidx][ch]})
                     - $signed({vtx_r[ch][31], vtx_r[ch]});
          end
          s_r   <= 64'd0;
          dot_r <= 51'sd0;
          cnt_r <= 6'd0;
        end
        S_SQ: begin
          s_r   <= s_r + sq_q;
          dot_r <= dot_r + 51'(dprod);
          cnt_r <= cnt_r + 6'd1;
        end
        S_ROOT0: begin
          srem_r <= s_r;
          res_r  <= 64'd0;
          sbit_r <= 64'h4000_0000_0000_0000;
          cq_r   <= dot_r[49:0];
          crem_r <= 32'd0;
          cnt_r  <= 6'd0;
          if (s_r == 64'd0 || dot_r <= 51'sd0) begin
            li_r <= li_inc;
          end
        end
        S_SQRT: begin
          if (srem_r >= strial) begin
            srem_r <= srem_r - strial;
            res_r  <= (res_r >> 1) + sbit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
        S_CDIV: begin
          crem_r <= cge ? 32'(cr2 - {1'b0, res_r[31:0]}) : cr2[31:0];
          cq_r   <= {cq_r[48:0], cge};
          cnt_r  <= cnt_r + 6'd1;
        end
        S_WCOL: begin
          for (int ch = 0; ch < 3; ch++) begin
            wcol_r[ch] <= col_prod[ch][31:14];
          end
        end
        S_WMUL: begin
          for (int ch = 0; ch < 3; ch++) begin
            w_r[ch] <= w_prod[ch];
            p_r[ch] <= 101'd0;
          end
          c2sh_r <= {13'd0, cq_r, 1'b0};
          cnt_r  <= 6'd0;
        end
        S_PMUL: begin
          // 16 multiplier bits a cycle, top chunk first
          for (int ch = 0; ch < 3; ch++) begin
            p_r[ch] <= 101'(p_r[ch] << 16) + 101'(pp[ch]);
          end
          c2sh_r <= c2sh_r << 16;
          cnt_r  <= cnt_r + 6'd1;
        end
        S_PDIV0: begin
          for (int ch = 0; ch < 3; ch++) begin
            psat_r[ch] <= (p_r[ch][100:32] >= {5'd0, s_r});
            prem_r[ch] <= p_r[ch][95:32];
            pq_r[ch]   <= p_r[ch][31:0];
          end
          cnt_r <= 6'd0;
        end
        S_PDIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            prem_r[ch] <= pge[ch] ? pdiff[ch][63:0] : pr2[ch][63:0];
            pq_r[ch]   <= {pq_r[ch][30:0], pge[ch]};
          end
          cnt_r <= cnt_r + 6'd1;
        end
        S_ACC: begin
          for (int ch = 0; ch < 3; ch++) begin
            if (accsum[ch][33:32] != 2'b00) begin
              acc_r[ch] <= 32'hFFFF_FFFF;
              clip_r    <= 1'b1;
            end else begin
              acc_r[ch] <= accsum[ch][31:0];
            end
          end
          li_r <= li_inc;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/lambert_vertex_lighting.sv
// Per-vertex Lambertian diffuse lighting from a table of up to MAX_LIGHTS point
// lights. A light-write beat (in_tuser 0) stores one slot and produces no output.
// A shade beat (in_tuser 1) produces one output beat with the saturated Q16.16
// rgb sums and a clip flag. A summed light whose scaled squared distance is zero
// or that faces away is skipped; each light that contributes runs through the
// back end's shared serial units: the 32-step square root, the 50-step quotient
// for the cosine term and the 32-step per-channel divide by the squared distance,
// with the three color channels run side by side. A two-beat queue between the
// input side and the shading engine accepts beats while a vertex is in progress,
// and a held output beat does not stop the next vertex.
// light_count is written through the cfg port while the block is idle; every slot
// below it must be loaded before shading.
module lambert_vertex_lighting #(
  parameter int MAX_LIGHTS = lvl_pkg::MAX_LIGHTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // light_slot, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
  // color_r, color_g, color_b, intensity, zero pad
  input  logic [lvl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // shade_r, shade_g, shade_b
  output logic [lvl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // clipped
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_data
);

  logic [2:0]    light_count_r;
  logic          job_valid;
  logic          job_pop;
  lvl_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_count_r <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      light_count_r <= cfg_data;
    end
  end

  lvl_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  lvl_back #(.MAX_LIGHTS(MAX_LIGHTS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .light_count (light_count_r),
    .job_valid   (job_valid),
    .job         (job),
    .job_pop     (job_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

### rtl/lvl_chk.sv
module lvl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lvl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[31:0] == 32'hFFFF_FFFF ||
                                 out_tdata[63:32] == 32'hFFFF_FFFF ||
                                 out_tdata[95:64] == 32'hFFFF_FFFF))
    else $error("clip flag without a saturated channel");

endmodule

bind lambert_vertex_lighting lvl_chk u_lvl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/testbench.sv
module testbench;

  localparam int NLIGHTS = lvl_pkg::MAX_LIGHTS_DEF;
  localparam longint LIMIT = 8000000;

  typedef struct {
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic        clip;
  } shade_t;

  class shade_board;
    logic [31:0] lpx[NLIGHTS], lpy[NLIGHTS], lpz[NLIGHTS];
    logic [15:0] lred[NLIGHTS], lgreen[NLIGHTS], lblue[NLIGHTS];
    logic [31:0] lpower[NLIGHTS];
    logic [2:0]  count;
    shade_t      pending[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < NLIGHTS; i++) begin
        lpx[i] = 0; lpy[i] = 0; lpz[i] = 0;
        lred[i] = 0; lgreen[i] = 0; lblue[i] = 0; lpower[i] = 0;
      end
      count = 0;
      errors = 0;
    endfunction

    function longint unsigned root_floor(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function shade_t light_vertex(lvl_pkg::job_t j);
      shade_t o;
      longint dx, dy, dz, dot, nx, ny, nz;
      longint unsigned ux, uy, uz, s, len, c, w, part;
      longint unsigned acc[3];
      logic [15:0] lc[3], kd[3];
      logic [127:0] prod, q;
      int n;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      o.clip = 0;
      kd[0] = j.color_r; kd[1] = j.color_g; kd[2] = j.color_b;
      nx = longint'(j.normal_x); ny = longint'(j.normal_y); nz = longint'(j.normal_z);
      n = (count > NLIGHTS) ? NLIGHTS : count;
      for (int i = 0; i < n; i++) begin
        dx = longint'($signed(lpx[i])) - longint'(j.pos_x);
        dy = longint'($signed(lpy[i])) - longint'(j.pos_y);
        dz = longint'($signed(lpz[i])) - longint'(j.pos_z);
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        uz = (dz < 0) ? -dz : dz;
        s = ((ux * ux) >> 2) + ((uy * uy) >> 2) + ((uz * uz) >> 2);
        if (s == 0) continue;
        len = root_floor(s);
        if (len == 0) continue;
        dot = dx * nx + dy * ny + dz * nz;
        if (dot <= 0) continue;
        c = longint'(dot) / len;
        lc[0] = lred[i]; lc[1] = lgreen[i]; lc[2] = lblue[i];
        for (int ch = 0; ch < 3; ch++) begin
          w = (((64'(lc[ch]) * 64'(kd[ch])) >> 14)) * 64'(lpower[i]);
          prod = 128'(w) * 128'(64'(c << 1));
          q = prod / 128'(s);
          part = (q > 128'h0FFFF_FFFF) ? 64'h1_0000_0000 : q[63:0];
          acc[ch] = acc[ch] + part;
          if (acc[ch] > 64'hFFFF_FFFF) begin
            acc[ch] = 64'hFFFF_FFFF;
            o.clip = 1;
          end
        end
      end
      o.r = acc[0][31:0]; o.g = acc[1][31:0]; o.b = acc[2][31:0];
      return o;
    endfunction

    function void note_input(lvl_pkg::job_t j);
      if (j.is_shade == lvl_pkg::OP_SHADE) begin
        pending.push_back(light_vertex(j));
      end else if (j.slot < NLIGHTS) begin
        lpx[j.slot] = j.pos_x; lpy[j.slot] = j.pos_y; lpz[j.slot] = j.pos_z;
        lred[j.slot] = j.color_r; lgreen[j.slot] = j.color_g;
        lblue[j.slot] = j.color_b; lpower[j.slot] = j.intensity;
      end
    endfunction

    function void check_result(logic [95:0] d, logic clip);
      shade_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat r=%h g=%h b=%h clip=%b",
                                   d[31:0], d[63:32], d[95:64], clip);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.r || d[63:32] !== e.g || d[95:64] !== e.b || clip !== e.clip) begin
        errors++;
        if (errors <= 10)
          $display("shade differs: exp r=%h g=%h b=%h clip=%b got r=%h g=%h b=%h clip=%b",
                   e.r, e.g, e.b, e.clip, d[31:0], d[63:32], d[95:64], clip);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [lvl_pkg::IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [lvl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_data;

  shade_board sb;
  longint cycles;
  int hold_off;

  lambert_vertex_lighting u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // output check and run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (cycles > LIMIT) begin
        $display("lambert_vertex_lighting: mismatch");
        $finish;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int rmode, left, phase;
    rmode = 0; left = 0; phase = 0;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        rmode = $urandom_range(0, 3);
        left = $urandom_range(20, 400);
      end
      left--;
      phase++;
      if (hold_off > 0) begin
        hold_off--;
        out_tready = 0;
      end else begin
        case (rmode)
          0: out_tready = 1;
          1: out_tready = ($urandom_range(0, 1) == 1);
          2: out_tready = (phase % 4 == 0);
          default: out_tready = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic logic [lvl_pkg::IN_TDATA_W-1:0] pack_job(lvl_pkg::job_t j);
    return {6'b0, j.intensity, j.color_b, j.color_g, j.color_r, j.normal_z, j.normal_y,
            j.normal_x, j.pos_z, j.pos_y, j.pos_x, j.slot};
  endfunction

  task automatic send_beat(lvl_pkg::job_t j);
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = j.is_shade;
    in_tdata = pack_job(j);
    do @(posedge clk); while (!in_tready);
    sb.note_input(j);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid = 0;
      in_tdata = '0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_gap(1);
    while (sb.pending.size() != 0) @(posedge clk);
    // writes still in flight produce no beat
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [2:0] v);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.count = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 16'h8000) - 16'h4000);
    endcase
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic lvl_pkg::job_t random_job(bit shade);
    lvl_pkg::job_t j;
    int k;
    j.is_shade = shade ? lvl_pkg::OP_SHADE : lvl_pkg::OP_WRITE;
    j.slot = 2'($urandom());
    j.pos_x = pick_pos(); j.pos_y = pick_pos(); j.pos_z = pick_pos();
    j.normal_x = pick_normal(); j.normal_y = pick_normal(); j.normal_z = pick_normal();
    j.color_r = pick_color(); j.color_g = pick_color(); j.color_b = pick_color();
    case ($urandom_range(0, 4))
      0: j.intensity = 32'hFFFF_FFFF;
      1: j.intensity = $urandom_range(0, 32'h0004_0000);
      default: j.intensity = $urandom();
    endcase
    // vertex sitting on a light
    if (shade && $urandom_range(0, 11) == 0) begin
      k = $urandom_range(0, NLIGHTS - 1);
      j.pos_x = sb.lpx[k]; j.pos_y = sb.lpy[k]; j.pos_z = sb.lpz[k];
    end
    return j;
  endfunction

  initial begin
    lvl_pkg::job_t j;
    logic [2:0] counts[16];
    int burst;
    sb = new();
    sb.reset_state();
    hold_off = 0;
    rst_n = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    cfg_valid = 0; cfg_data = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // load every slot, with extreme positions in slots 0 and 1
    for (int i = 0; i < NLIGHTS; i++) begin
      j = random_job(0);
      j.slot = 2'(i);
      if (i == 0) begin
        j.pos_x = 32'h7FFF_FFFF; j.pos_y = 32'h7FFF_FFFF; j.pos_z = 32'h7FFF_FFFF;
        j.color_r = 16'hFFFF; j.color_g = 16'hFFFF; j.color_b = 16'hFFFF;
        j.intensity = 32'hFFFF_FFFF;
      end else if (i == 1) begin
        j.pos_x = 32'h8000_0000; j.pos_y = 32'h8000_0000; j.pos_z = 32'h8000_0000;
      end else if (i == 2) begin
        j.pos_x = 0; j.pos_y = 0; j.pos_z = 32'h0001_0000;
        j.color_r = 16'h4000; j.color_g = 16'h4000; j.color_b = 16'h4000;
        j.intensity = 32'h0001_0000;
      end
      send_beat(j);
    end
    wait_drained();
    write_count(3'd4);

    // directed shades, the last six random
    for (int i = 0; i < 12; i++) begin
      j = random_job(1);
      case (i)
        0: begin
          j.pos_x = 0; j.pos_y = 0; j.pos_z = 0;
          j.normal_x = 0; j.normal_y = 0; j.normal_z = 16'h4000;
        end
        1: begin
          j.pos_x = 0; j.pos_y = 0; j.pos_z = 0;
          j.normal_x = 0; j.normal_y = 0; j.normal_z = 16'hC000;
        end
        2: begin
          j.pos_x = 0; j.pos_y = 0; j.pos_z = 32'h0001_0000;
        end
        3: begin
          j.pos_x = 32'h8000_0000; j.pos_y = 32'h8000_0000; j.pos_z = 32'h8000_0000;
          j.normal_x = 16'h7FFF; j.normal_y = 16'h7FFF; j.normal_z = 16'h7FFF;
          j.color_r = 16'hFFFF; j.color_g = 16'hFFFF; j.color_b = 16'hFFFF;
        end
        4: begin
          j.pos_x = 32'h7FFF_FFFF; j.pos_y = 32'h7FFF_FFFF; j.pos_z = 32'h7FFF_FFFF;
          j.normal_x = 16'h8000; j.normal_y = 16'h8000; j.normal_z = 16'h8000;
        end
        5: begin
          j.color_r = 0; j.color_g = 0; j.color_b = 0;
        end
        default: ;
      endcase
      send_beat(j);
      idle_gap($urandom_range(0, 3));
    end

    counts = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
               3'd1, 3'd2, 3'd4, 3'd0, 3'd3, 3'd7, 3'd2, 3'd1};
    for (int p = 0; p < 16; p++) begin
      wait_drained();
      write_count(counts[p]);
      burst = 0;
      for (int n = 0; n < 108; n++) begin
        // let the output back up so the input side stalls
        if (p == 3 && n == 10) hold_off = 3000;
        send_beat(random_job($urandom_range(0, 3) != 0));
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          idle_gap($urandom_range(0, 1) == 1 ? $urandom_range(1, 40) : 0);
        end else begin
          burst--;
        end
      end
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lambert_vertex_lighting: match");
    end else begin
      $display("lambert_vertex_lighting: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lvl_pkg.sv
rtl/lvl_front.sv
rtl/lvl_back.sv
rtl/lambert_vertex_lighting.sv
rtl/lvl_chk.sv
tb/sv/testbench.sv
